[rtl/tsbe_pkg.sv]
// Shared types, constants and the microprogram of the tagged stack executor.
package tsbe_pkg;

  // Stack geometry.
  localparam int unsigned STACK_WORDS = 256;
  localparam int unsigned ADDR_W      = $clog2(STACK_WORDS);
  localparam int unsigned CNT_W       = $clog2(STACK_WORDS + 1);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STAT_W      = 3;

  // Tag constants of the packed words.
  localparam logic [1:0]        CONS_TAG_LO = 2'b11;
  localparam logic [1:0]        CONS_TAG_HI = 2'b10;
  localparam logic [3:0]        COMP_TAG    = 4'b0010;
  localparam logic [7:0]        SUBR_TAG    = 8'h06;
  localparam logic [WORD_W-1:0] NIL_WORD    = 32'h0000_0016;
  localparam logic [WORD_W-1:0] INT_ONE     = 32'h0000_0004;

  typedef enum logic [7:0] {
    OP_INT  = 8'd1,
    OP_CONS = 8'd2,
    OP_NIL  = 8'd3,
    OP_COMP = 8'd4,
    OP_SUBR = 8'd5,
    OP_INC  = 8'd6,
    OP_ADD  = 8'd7
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_ILLEGAL   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_FULL      = 3'd4,
    ST_HALTED    = 3'd5
  } status_e;

  // Microprogram addresses.
  typedef enum logic [2:0] {
    UA_IDLE   = 3'd0,
    UA_DECODE = 3'd1,
    UA_PUSH   = 3'd2,
    UA_RDA    = 3'd3,
    UA_RDB    = 3'd4,
    UA_SUM    = 3'd5,
    UA_EMIT   = 3'd6
  } uaddr_e;

  // Sequencer operations.
  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_WAIT_IN,
    SQ_DISPATCH,
    SQ_GOTO,
    SQ_WAIT_OUT
  } seq_op_e;

  // One control word of the microprogram.
  typedef struct packed {
    seq_op_e seq;
    uaddr_e  target;
    logic    ld_in;     // capture the request payload
    logic    chk;       // run the decode checks, set the status
    logic    push_imm;  // push the packed immediate word
    logic    rd_top;    // read the top word and pop it
    logic    pop_b;     // latch the first operand, pop the second for add
    logic    sum;       // add, check overflow, push the sum
    logic    emit;      // load the result register
  } ucw_t;

  // Datapath status seen by the sequencer and the checks.
  typedef struct packed {
    logic             fault;
    logic             is_push;
    logic             out_free;
    logic             halted;
    logic [CNT_W-1:0] count;
  } dp_stat_t;

  // The microprogram ROM.
  function automatic ucw_t ucode(uaddr_e a);
    ucw_t w;
    w = '{seq: SQ_NEXT, target: UA_IDLE, default: 1'b0};
    case (a)
      UA_IDLE: begin
        w.seq   = SQ_WAIT_IN;
        w.ld_in = 1'b1;
      end
      UA_DECODE: begin
        w.seq = SQ_DISPATCH;
        w.chk = 1'b1;
      end
      UA_PUSH: begin
        w.seq      = SQ_GOTO;
        w.target   = UA_EMIT;
        w.push_imm = 1'b1;
      end
      UA_RDA:  w.rd_top = 1'b1;
      UA_RDB:  w.pop_b  = 1'b1;
      UA_SUM:  w.sum    = 1'b1;
      UA_EMIT: begin
        w.seq    = SQ_WAIT_OUT;
        w.target = UA_IDLE;
        w.emit   = 1'b1;
      end
      default: begin
        w.seq    = SQ_GOTO;
        w.target = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/tsbe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsbe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tsbe_seq.sv]
// Microcode sequencer: step counter, control ROM and jump logic.
module tsbe_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  tsbe_pkg::dp_stat_t stat_i,
  output tsbe_pkg::ucw_t    ctl_o,
  output logic              in_ready_o
);
  import tsbe_pkg::*;

  uaddr_e upc_q, upc_d;
  ucw_t   ctl;

  assign ctl        = ucode(upc_q);
  assign ctl_o      = ctl;
  assign in_ready_o = (ctl.seq == SQ_WAIT_IN);

  // Next step selection.
  always_comb begin
    upc_d = upc_q;
    case (ctl.seq)
      SQ_NEXT:    upc_d = uaddr_e'(upc_q + 3'd1);
      SQ_WAIT_IN: begin
        if (in_valid_i) begin
          upc_d = uaddr_e'(upc_q + 3'd1);
        end
      end
      SQ_DISPATCH: begin
        if (stat_i.fault) begin
          upc_d = UA_EMIT;
        end else if (stat_i.is_push) begin
          upc_d = UA_PUSH;
        end else begin
          upc_d = UA_RDA;
        end
      end
      SQ_GOTO:    upc_d = ctl.target;
      SQ_WAIT_OUT: begin
        if (stat_i.out_free) begin
          upc_d = ctl.target;
        end
      end
      default:    upc_d = UA_IDLE;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[rtl/tsbe_dp.sv]
// Datapath: operand latch, word packer, stack memory, adder and result register.
module tsbe_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsbe_pkg::ucw_t                ctl_i,
  input  logic [tsbe_pkg::BYTE_W-1:0]   opcode_i,
  input  logic [tsbe_pkg::BYTE_W-1:0]   operand_first_i,
  input  logic [tsbe_pkg::BYTE_W-1:0]   operand_second_i,
  input  logic [tsbe_pkg::BYTE_W-1:0]   operand_third_i,
  input  logic [tsbe_pkg::BYTE_W-1:0]   operand_fourth_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tsbe_pkg::WORD_W-1:0]   pushed_word_o,
  output logic [tsbe_pkg::STAT_W-1:0]   status_o,
  output logic [tsbe_pkg::CNT_W-1:0]    depth_after_o,
  output tsbe_pkg::dp_stat_t            stat_o
);
  import tsbe_pkg::*;

  // Latched request.
  logic [BYTE_W-1:0] op_q, o1_q, o2_q, o3_q, o4_q;
  // Working registers.
  logic [WORD_W-1:0] word_q, a_q;
  status_e           status_q;
  // Control state.
  logic [CNT_W-1:0]  count_q, count_d;
  logic              halted_q, halted_d;
  logic              out_valid_q, out_valid_d;
  // Result register.
  logic [WORD_W-1:0] res_word_q;
  status_e           res_status_q;
  logic [CNT_W-1:0]  res_depth_q;

  logic [WORD_W-1:0] imm_word, rdata, b_val, sum;
  logic [CNT_W-1:0]  count_m1;
  logic              is_push, is_add, ovf, out_free, emit_go;
  status_e           chk_status;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata;

  assign is_add   = (op_q == OP_ADD);
  assign count_m1 = count_q - CNT_W'(1);
  assign out_free = !out_valid_q || out_ready_i;
  assign emit_go  = ctl_i.emit && out_free;

  // Word packer and decode checks.
  always_comb begin
    imm_word   = '0;
    is_push    = 1'b1;
    chk_status = ST_OK;
    case (op_q)
      OP_INT:  imm_word = {o4_q, o3_q, o2_q, o1_q[7:2], 2'b00};
      OP_CONS: imm_word = {o4_q, o3_q[7:2], CONS_TAG_HI, o2_q, o1_q[7:2], CONS_TAG_LO};
      OP_NIL:  imm_word = NIL_WORD;
      OP_COMP: imm_word = {o4_q, o3_q, o2_q, o1_q[7:4], COMP_TAG};
      OP_SUBR: imm_word = {o2_q, o1_q, 8'h00, SUBR_TAG};
      OP_INC, OP_ADD: is_push = 1'b0;
      default: begin
        is_push    = 1'b0;
        chk_status = ST_ILLEGAL;
      end
    endcase
    if (halted_q) begin
      chk_status = ST_HALTED;
    end else if (chk_status == ST_OK) begin
      if (is_push) begin
        if (count_q == CNT_W'(STACK_WORDS)) begin
          chk_status = ST_FULL;
        end
      end else if (count_q == '0 || (is_add && count_q == CNT_W'(1))) begin
        chk_status = ST_UNDERFLOW;
      end
    end
  end

  // Adder and signed overflow check.
  assign b_val = is_add ? rdata : INT_ONE;
  assign sum   = a_q + b_val;
  assign ovf   = (a_q[WORD_W-1] ^ sum[WORD_W-1]) & (b_val[WORD_W-1] ^ sum[WORD_W-1]);

  // Stack memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[ADDR_W-1:0];
    ram_wdata = imm_word;
    ram_re    = 1'b0;
    ram_raddr = count_m1[ADDR_W-1:0];
    if (ctl_i.push_imm) begin
      ram_we = 1'b1;
    end
    if (ctl_i.sum && !ovf) begin
      ram_we    = 1'b1;
      ram_wdata = sum;
    end
    if (ctl_i.rd_top || (ctl_i.pop_b && is_add)) begin
      ram_re = 1'b1;
    end
  end

  tsbe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_WORDS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // Next values of the control state.
  always_comb begin
    count_d     = count_q;
    halted_d    = halted_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctl_i.push_imm || (ctl_i.sum && !ovf)) begin
      count_d = count_q + CNT_W'(1);
    end
    if (ctl_i.rd_top || (ctl_i.pop_b && is_add)) begin
      count_d = count_m1;
    end
    if (emit_go) begin
      out_valid_d = 1'b1;
      if (status_q != ST_OK) begin
        halted_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_in) begin
      op_q <= opcode_i;
      o1_q <= operand_first_i;
      o2_q <= operand_second_i;
      o3_q <= operand_third_i;
      o4_q <= operand_fourth_i;
    end
    if (ctl_i.chk) begin
      status_q <= chk_status;
      word_q   <= '0;
    end
    if (ctl_i.push_imm) begin
      word_q <= imm_word;
    end
    if (ctl_i.pop_b) begin
      a_q <= rdata;
    end
    if (ctl_i.sum) begin
      if (ovf) begin
        status_q <= ST_OVERFLOW;
      end else begin
        word_q <= sum;
      end
    end
    if (emit_go) begin
      res_word_q   <= word_q;
      res_status_q <= status_q;
      res_depth_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pushed_word_o = res_word_q;
  assign status_o      = res_status_q;
  assign depth_after_o = res_depth_q;

  assign stat_o = '{
    fault:    (chk_status != ST_OK),
    is_push:  is_push,
    out_free: out_free,
    halted:   halted_q,
    count:    count_q
  };

endmodule

[rtl/tagged_stack_bytecode_executor.sv]
// Top level of the tagged stack bytecode executor.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | input     | in_valid_i/in_ready_o | opcode, operand_first..operand_fourth
//   out     | output    | out_valid_o/out_ready_i | pushed_word, status, depth_after
//
// One instruction at a time, stepped by the microprogram over the single-read stack RAM:
// a push runs through decode, push and emit; inc and add through decode, read, latch, sum
// and emit (add reads two words, inc one, and the read data is registered); a fault or an
// already-halted request goes from decode straight to emit. The result register frees the
// sequencer; it stalls only in its emit step while an earlier result is still waiting.
// Reset empties the stack and clears the halt flag; the stack RAM needs no clearing pass.
module tagged_stack_bytecode_executor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tsbe_pkg::BYTE_W-1:0] opcode_i,
  input  logic [tsbe_pkg::BYTE_W-1:0] operand_first_i,
  input  logic [tsbe_pkg::BYTE_W-1:0] operand_second_i,
  input  logic [tsbe_pkg::BYTE_W-1:0] operand_third_i,
  input  logic [tsbe_pkg::BYTE_W-1:0] operand_fourth_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tsbe_pkg::WORD_W-1:0] pushed_word_o,
  output logic [tsbe_pkg::STAT_W-1:0] status_o,
  output logic [tsbe_pkg::CNT_W-1:0]  depth_after_o
);
  import tsbe_pkg::*;

  ucw_t     ctl;
  dp_stat_t stat;

  // Sequencer.
  tsbe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .in_ready_o (in_ready_o)
  );

  // Datapath.
  tsbe_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .opcode_i         (opcode_i),
    .operand_first_i  (operand_first_i),
    .operand_second_i (operand_second_i),
    .operand_third_i  (operand_third_i),
    .operand_fourth_i (operand_fourth_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .pushed_word_o    (pushed_word_o),
    .status_o         (status_o),
    .depth_after_o    (depth_after_o),
    .stat_o           (stat)
  );

  // The stack depth never goes past the stack size.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= CNT_W'(STACK_WORDS))
    else $error("stack depth beyond capacity");

  // Once halted, the block stays halted.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.halted |=> stat.halted)
    else $error("halt flag cleared without reset");

  // A faulting result never carries a pushed word.
  a_fault_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (pushed_word_o == '0))
    else $error("fault result with nonzero word");

  // The depth does not change while the sequencer waits for a request.
  a_idle_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !in_valid_i) |=> $stable(stat.count))
    else $error("stack depth changed while idle");

endmodule
